### rtl/core/mmr_pkg.sv
// shared types and constants for the mountain range position calculator
// no dependencies; imported by mmr_search, mmr_peak_walk, the top level and the testbench
package mmr_pkg;

    localparam int OPER_W = 62;   // operand width
    localparam int IDX_W  = 64;   // position and count width
    localparam int HGT_W  = 6;    // node height width
    localparam int CNT_W  = 6;    // bit and run counters

    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 264;
    localparam int M_USER_W = 3;

    // commands
    localparam logic [1:0] CMD_NODE_INFO  = 2'd0;
    localparam logic [1:0] CMD_PEAKS      = 2'd1;
    localparam logic [1:0] CMD_LEAF_COUNT = 2'd2;
    localparam logic [1:0] CMD_LEAF_POS   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    // leaf search outcome: n leaves, f = 2n - popcount(n), trailing ones of n
    typedef struct packed {
        logic [OPER_W-1:0] n;
        logic [IDX_W-1:0]  f;
        logic [CNT_W-1:0]  run;
    } t_srch_res;

    // one peak of a complete range
    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] size;
        logic             last;
    } t_peak;

endpackage

### rtl/core/mmr_position_calculator_top.sv
// mountain range position calculator, postorder numbering, top level
// node info, leaf count, leaf position and peaks of an empty or incomplete size: the
// 62-bit serial leaf search runs to its end, then the result goes to the output register
// valid peaks: once the search is done the walker takes the bits of the leaf count from
// the top, one per cycle while no peak waits on the output, one peak per set bit
// one item at a time, next word taken once the last is registered
// reset: synchronous active-low i_rst_n clears the sequencer, search, walker and output valid
module mmr_position_calculator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [mmr_pkg::S_DATA_W-1:0] s_axis_tdata,  // [61:0] operand_value, [63:62] zero
    input  logic [mmr_pkg::S_USER_W-1:0] s_axis_tuser,  // [1:0] command
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [5:0] node_height, [69:6] index_a, [133:70] index_b, [197:134] index_c,
    // [261:198] index_d, [263:262] zero
    output logic [mmr_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [mmr_pkg::M_USER_W-1:0] m_axis_tuser,  // [0] leaf_flag, [2:1] status
    output logic                         m_axis_tlast
);
    import mmr_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;
    localparam logic [1:0] S_PEAKS  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [1:0]        r_cmd;
    logic [OPER_W-1:0] r_v;

    logic              in_fire;
    logic              srch_busy;
    t_srch_res         srch_res;

    logic              walk_start;
    logic              walk_ready;
    logic              walk_valid;
    logic              walk_fire;
    t_peak             walk_peak;

    logic              out_free;
    logic              res_load;

    // output register
    logic                r_m_tvalid;
    logic [M_DATA_W-1:0] r_m_tdata;
    logic [M_USER_W-1:0] r_m_tuser;
    logic                r_m_tlast;
    logic [M_DATA_W-1:0] n_m_tdata;
    logic [M_USER_W-1:0] n_m_tuser;
    logic                n_m_tlast;

    // node arithmetic
    logic [IDX_W-1:0] v64;
    logic [IDX_W-1:0] v_inc;
    logic [IDX_W-1:0] v_diff;
    logic [HGT_W-1:0] hgt;
    logic [HGT_W:0]   hgt_inc;
    logic [IDX_W-1:0] p2;
    logic [IDX_W-1:0] ph;
    logic [IDX_W-1:0] v_p2;
    logic             right_sib;
    logic             peaks_ok;

    // selected result fields
    logic [HGT_W-1:0] sel_hgt;
    logic [IDX_W-1:0] sel_a;
    logic [IDX_W-1:0] sel_b;
    logic [IDX_W-1:0] sel_c;
    logic [IDX_W-1:0] sel_d;
    logic             sel_leaf;
    logic [1:0]       sel_status;
    logic             sel_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // serial leaf search, forced to the operand bits for leaf position
    mmr_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_x     (s_axis_tdata[OPER_W-1:0]),
        .i_force (s_axis_tuser == CMD_LEAF_POS),
        .o_busy  (srch_busy),
        .o_res   (srch_res)
    );

    // a complete size has exactly f(n) nodes; its peaks follow the set bits of n
    assign peaks_ok   = (r_v != '0) && (srch_res.f == v64);
    assign walk_start = (r_state == S_RESULT) && (r_cmd == CMD_PEAKS) && peaks_ok;
    assign walk_ready = (r_state == S_PEAKS) && out_free;
    assign walk_fire  = walk_valid && walk_ready;

    mmr_peak_walk u_peak_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_n     (srch_res.n),
        .i_ready (walk_ready),
        .o_valid (walk_valid),
        .o_peak  (walk_peak)
    );

    // node heights: leaf n sits at f(n), followed by run parents of rising height,
    // so the height is the distance from f(n) and the node is a right sibling below the top
    assign v64       = {2'b00, r_v};
    assign v_inc     = v64 + IDX_W'(1);
    assign v_diff    = v64 - srch_res.f;
    assign hgt       = v_diff[HGT_W-1:0];
    assign hgt_inc   = {1'b0, hgt} + (HGT_W + 1)'(1);
    assign p2        = IDX_W'(1) << hgt_inc;
    assign ph        = IDX_W'(1) << hgt;
    assign v_p2      = v64 + p2;
    assign right_sib = (hgt < srch_res.run);

    always_comb begin
        sel_hgt    = '0;
        sel_a      = '0;
        sel_b      = '0;
        sel_c      = '0;
        sel_d      = '0;
        sel_leaf   = 1'b0;
        sel_status = ST_OK;
        sel_last   = 1'b1;
        unique case (r_cmd)
            CMD_NODE_INFO: begin
                sel_hgt  = hgt;
                sel_a    = right_sib ? v_inc : v_p2;
                sel_b    = right_sib ? (v_inc - p2) : (v_p2 - IDX_W'(1));
                sel_leaf = (hgt == '0);
                if (hgt != '0) begin
                    sel_c = v64 - ph;
                    sel_d = v64 - IDX_W'(1);
                end
            end
            CMD_PEAKS: begin
                // only error results come from here; complete sizes go to the walker
                sel_status = (r_v == '0) ? ST_EMPTY : ST_INCOMPLETE;
            end
            CMD_LEAF_COUNT: begin
                // next complete size is f(n+1) = f(n) + 1 + trailing ones of n
                sel_a = srch_res.f + IDX_W'(1) + IDX_W'(srch_res.run);
                sel_b = {2'b00, srch_res.n} + IDX_W'(1);
            end
            CMD_LEAF_POS: begin
                // forced search leaves 2v - popcount(v)
                sel_a = srch_res.f;
            end
            default: begin
                sel_a = '0;
            end
        endcase
    end

    assign out_free = !r_m_tvalid || m_axis_tready;
    assign res_load = (r_state == S_RESULT) && !walk_start && out_free;

    // next word for the output register
    always_comb begin
        if (r_state == S_PEAKS) begin
            n_m_tdata = {2'b00, IDX_W'(0), IDX_W'(0), walk_peak.size, walk_peak.pos,
                         HGT_W'(0)};
            n_m_tuser = {ST_OK, 1'b0};
            n_m_tlast = walk_peak.last;
        end else begin
            n_m_tdata = {2'b00, sel_d, sel_c, sel_b, sel_a, sel_hgt};
            n_m_tuser = {sel_status, sel_leaf};
            n_m_tlast = sel_last;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (!srch_busy) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (walk_start) begin
                    n_state = S_PEAKS;
                end else if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            S_PEAKS: begin
                if (walk_fire && walk_peak.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= s_axis_tuser;
            r_v   <= s_axis_tdata[OPER_W-1:0];
        end
    end

    // output register, refilled in the cycle its word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_load || walk_fire) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load || walk_fire) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= n_m_tuser;
            r_m_tlast <= n_m_tlast;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tlast  = r_m_tlast;

endmodule

### rtl/core/mmr_search.sv
// bit-serial leaf search: largest n with 2n - popcount(n) <= x, one bit of n per cycle
// forced mode takes the bits of x itself, giving 2x - popcount(x)
// depends on mmr_pkg
module mmr_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mmr_pkg::OPER_W-1:0] i_x,
    input  logic                      i_force,
    output logic                      o_busy,
    output mmr_pkg::t_srch_res        o_res
);
    import mmr_pkg::*;

    logic [OPER_W-1:0] r_mask;
    logic [OPER_W-1:0] r_x;
    logic              r_force;
    logic [OPER_W-1:0] r_n;
    logic [IDX_W-1:0]  r_f;
    logic [CNT_W-1:0]  r_pc;
    logic [CNT_W-1:0]  r_run;

    logic [OPER_W-1:0] cand_n;
    logic [CNT_W:0]    pc_inc;
    logic [IDX_W-1:0]  cand_f;
    logic              take;

    assign o_busy = |r_mask;

    // candidate with the current bit set; lower bits still clear
    assign cand_n = r_n | r_mask;
    assign pc_inc = {1'b0, r_pc} + (CNT_W + 1)'(1);
    assign cand_f = {1'b0, cand_n, 1'b0} - IDX_W'(pc_inc);
    assign take   = r_force ? (|(r_x & r_mask)) : (cand_f <= {2'b00, r_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_start) begin
            r_mask <= {1'b1, {(OPER_W-1){1'b0}}};
        end else if (o_busy) begin
            r_mask <= r_mask >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x     <= i_x;
            r_force <= i_force;
            r_n     <= '0;
            r_f     <= '0;
            r_pc    <= '0;
            r_run   <= '0;
        end else if (o_busy) begin
            if (take) begin
                r_n   <= cand_n;
                r_f   <= cand_f;
                r_pc  <= r_pc + CNT_W'(1);
                r_run <= r_run + CNT_W'(1);
            end else begin
                r_run <= '0;
            end
        end
    end

    assign o_res.n   = r_n;
    assign o_res.f   = r_f;
    assign o_res.run = r_run;

endmodule

### rtl/core/mmr_peak_walk.sv
// peak walker: steps through the bits of a leaf count from the top, one per cycle while no
// peak waits on i_ready, and hands out one peak per set bit with its position and size
// depends on mmr_pkg
module mmr_peak_walk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mmr_pkg::OPER_W-1:0] i_n,
    input  logic                       i_ready,
    output logic                       o_valid,
    output mmr_pkg::t_peak             o_peak
);
    import mmr_pkg::*;

    logic [OPER_W-1:0] r_mask;
    logic [OPER_W-1:0] r_size;
    logic [OPER_W-1:0] r_rest;
    logic [OPER_W-1:0] r_prev;

    logic hit;
    logic advance;

    assign hit     = |(r_rest & r_mask);
    assign advance = (|r_mask) && (!hit || i_ready);
    assign o_valid = hit;

    // size is all ones, so size - 1 just clears bit zero
    assign o_peak.pos  = {2'b00, r_prev + {r_size[OPER_W-1:1], 1'b0}};
    assign o_peak.size = {2'b00, r_size};
    assign o_peak.last = (r_rest == r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_start) begin
            r_mask <= {1'b1, {(OPER_W-1){1'b0}}};
        end else if (advance) begin
            r_mask <= r_mask >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_size <= '1;
            r_rest <= i_n;
            r_prev <= '0;
        end else if (advance) begin
            r_size <= r_size >> 1;
            if (hit) begin
                r_rest <= r_rest & ~r_mask;
                r_prev <= r_prev + r_size;
            end
        end
    end

endmodule

### tb/mmr_position_calculator_top_tb.sv
// self-checking bench for the mountain range position calculator top level
// depends on mmr_pkg and mmr_position_calculator_top; random idling on both stream sides
module mmr_position_calculator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmr_pkg::*;

    localparam logic [OPER_W-1:0] OPND_MAX = '1;

    // one command word as it goes into the block
    typedef struct packed {
        logic [1:0]        cmd;
        logic [OPER_W-1:0] opnd;
    } t_cmd_word;

    // one position word as it comes out of the block
    typedef struct packed {
        logic [HGT_W-1:0] height;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
        logic             leaf;
        logic [1:0]       status;
        logic             last;
    } t_pos_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // [61:0] operand_value, [63:62] zero
    logic [S_USER_W-1:0] s_axis_tuser = '0;   // [1:0] command
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [5:0] node_height, [69:6] index_a, [133:70] index_b, [197:134] index_c,
    // [261:198] index_d, [263:262] zero
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;        // [0] leaf_flag, [2:1] status
    logic                m_axis_tlast;

    t_cmd_word   cmd_words[$];       // words still to be offered
    t_pos_word   positions_due[$];   // predicted position words, oldest first

    int unsigned n_in_sent  = 0;     // words put on the input bus
    int unsigned n_in_acc   = 0;     // words the block has taken
    int unsigned n_out_acc  = 0;     // words taken from the block
    int unsigned n_out_seen = 0;
    int unsigned in_wait    = 0;
    int unsigned out_wait   = 0;
    logic [31:0] cyc        = '0;
    int          n_errors   = 0;

    mmr_position_calculator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---------------------------------------------------------------
    // position arithmetic, all sums modulo 2^64
    // ---------------------------------------------------------------

    // copy the top set bit into every bit below it
    function automatic logic [IDX_W-1:0] smear(input logic [IDX_W-1:0] x);
        x = x | (x >> 1);
        x = x | (x >> 2);
        x = x | (x >> 4);
        x = x | (x >> 8);
        x = x | (x >> 16);
        x = x | (x >> 32);
        return x;
    endfunction

    // strip all-ones peak sizes from the position, largest first
    function automatic logic [IDX_W-1:0] height_of(input logic [IDX_W-1:0] pos);
        logic [IDX_W-1:0] h;
        logic [IDX_W-1:0] ps;
        h  = pos;
        ps = smear(pos + 64'd1);
        while (ps != 0) begin
            if (h >= ps) begin
                h = h - ps;
            end
            ps = ps >> 1;
        end
        return h;
    endfunction

    // power of two that vanishes once the exponent leaves 64 bits
    function automatic logic [IDX_W-1:0] bit_weight(input logic [IDX_W-1:0] e);
        return (e < 64) ? (64'd1 << e) : 64'd0;
    endfunction

    function automatic logic [IDX_W-1:0] ones_in(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] n;
        n = 0;
        for (int i = 0; i < IDX_W; i++) begin
            n = n + IDX_W'(x[i]);
        end
        return n;
    endfunction

    // queue one predicted word behind the ones already due
    task automatic add_due(input t_pos_word w);
        positions_due.insert(positions_due.size(), w);
    endtask

    // predicted position words for one accepted command word
    task automatic work_out_positions(input logic [1:0] cmd, input logic [OPER_W-1:0] opnd);
        logic [IDX_W-1:0] v, h, nh, p2, ps, left, prev, cnt, leaves;
        int               n;
        int               steps;
        t_pos_word        r;
        t_pos_word        peak_list[$];
        v = {{(IDX_W-OPER_W){1'b0}}, opnd};
        r = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_NODE_INFO: begin
                h  = height_of(v);
                p2 = bit_weight(h + 64'd1);
                // right sibling when the next position sits one level up
                if (height_of(v + 64'd1) == h + 64'd1) begin
                    r.a = v + 64'd1;
                    r.b = v + 64'd1 - p2;
                end else begin
                    r.a = v + p2;
                    r.b = v + p2 - 64'd1;
                end
                if (h != 0) begin
                    r.c = v - bit_weight(h);
                    r.d = v - 64'd1;
                end
                r.height = h[HGT_W-1:0];
                r.leaf   = (h == 0);
                add_due(r);
            end
            CMD_PEAKS: begin
                if (v == 0) begin
                    r.status = ST_EMPTY;
                    add_due(r);
                end else begin
                    ps   = smear(v);
                    left = v;
                    prev = 0;
                    n    = 0;
                    r.last = 1'b0;
                    while (ps != 0) begin
                        if (left >= ps && n < 64) begin
                            r.a = prev + ps - 64'd1;
                            r.b = ps;
                            peak_list.insert(peak_list.size(), r);
                            n    = n + 1;
                            prev = prev + ps;
                            left = left - ps;
                        end
                        ps = ps >> 1;
                    end
                    if (left != 0 || n == 0) begin
                        r        = '0;
                        r.status = ST_INCOMPLETE;
                        r.last   = 1'b1;
                        add_due(r);
                    end else begin
                        peak_list[n-1].last = 1'b1;
                        foreach (peak_list[k]) begin
                            add_due(peak_list[k]);
                        end
                    end
                end
            end
            CMD_LEAF_COUNT: begin
                // walk forward while the height keeps rising
                cnt   = v;
                h     = height_of(cnt);
                cnt   = cnt + 64'd1;
                nh    = height_of(cnt);
                steps = 0;
                while (nh > h && steps < 64) begin
                    h     = nh;
                    cnt   = cnt + 64'd1;
                    nh    = height_of(cnt);
                    steps = steps + 1;
                end
                ps     = smear(cnt);
                left   = cnt;
                leaves = 0;
                while (ps != 0) begin
                    if (left >= ps) begin
                        leaves = leaves + (ps + 64'd1) / 2;
                        left   = left - ps;
                    end
                    ps = ps >> 1;
                end
                r.a = cnt;
                r.b = leaves;
                add_due(r);
            end
            CMD_LEAF_POS: begin
                r.a = 64'd2 * v - ones_in(v);
                add_due(r);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic add_cmd(input logic [1:0] cmd, input logic [OPER_W-1:0] opnd);
        t_cmd_word w;
        w.cmd  = cmd;
        w.opnd = opnd;
        cmd_words.insert(cmd_words.size(), w);
    endtask

    // random value of random bit length, full width at least a quarter of the time
    function automatic logic [OPER_W-1:0] spread_value();
        int          w;
        logic [63:0] x;
        w = ($urandom_range(0, 3) == 0) ? OPER_W : $urandom_range(1, OPER_W);
        x = {$urandom, $urandom};
        return x[OPER_W-1:0] & ((62'd1 << w) - 62'd1);
    endfunction

    function automatic int unsigned draw_wait(input logic calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic check_field(input string name, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            n_errors = n_errors + 1;
        end
    endtask

    // ---------------------------------------------------------------
    // clock, reset and timeout
    // ---------------------------------------------------------------

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // single reset pulse at the start
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // input driver: offers queued command words, random gap after each
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin : drive_cmd
        t_cmd_word w;
        // hold the current word until the monitor has seen it taken
        if (i_rst_n && !(s_axis_tvalid && n_in_acc != n_in_sent)) begin
            if (in_wait != 0) begin
                s_axis_tvalid <= 1'b0;
                in_wait       <= in_wait - 1;
            end else if (cmd_words.size() != 0) begin
                w = cmd_words.pop_front();
                s_axis_tdata  <= {{(S_DATA_W-OPER_W){1'b0}}, w.opnd};
                s_axis_tuser  <= w.cmd;
                s_axis_tvalid <= 1'b1;
                n_in_sent     <= n_in_sent + 1;
                // one stretch in eight runs without gaps, while bits [13:11] of cyc are all ones
                in_wait       <= draw_wait(cyc[13:11] == 3'b111);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // output stall: after each taken word, ready drops for a random count
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin : drive_ready
        int unsigned g;
        g = out_wait;
        if (n_out_acc != n_out_seen) begin
            g = draw_wait(cyc[13:11] == 3'b010);
        end
        n_out_seen <= n_out_acc;
        if (g != 0) begin
            m_axis_tready <= 1'b0;
            out_wait      <= g - 1;
        end else begin
            m_axis_tready <= 1'b1;
            out_wait      <= 0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: predicts on input words, checks output words in order
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : watch_bus
        t_pos_word got;
        t_pos_word want;
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_out_acc <= n_out_acc + 1;
                got.height = m_axis_tdata[HGT_W-1:0];
                got.a      = m_axis_tdata[HGT_W +: IDX_W];
                got.b      = m_axis_tdata[HGT_W+IDX_W +: IDX_W];
                got.c      = m_axis_tdata[HGT_W+2*IDX_W +: IDX_W];
                got.d      = m_axis_tdata[HGT_W+3*IDX_W +: IDX_W];
                got.leaf   = m_axis_tuser[0];
                got.status = m_axis_tuser[2:1];
                got.last   = m_axis_tlast;
                if (positions_due.size() == 0) begin
                    $display("%0t: no word expected, actual index_a %0h status %0d",
                             $time, got.a, got.status);
                    n_errors = n_errors + 1;
                end else begin
                    want = positions_due.pop_front();
                    check_field("node_height", IDX_W'(want.height), IDX_W'(got.height));
                    check_field("index_a", want.a, got.a);
                    check_field("index_b", want.b, got.b);
                    check_field("index_c", want.c, got.c);
                    check_field("index_d", want.d, got.d);
                    check_field("leaf_flag", IDX_W'(want.leaf), IDX_W'(got.leaf));
                    check_field("status", IDX_W'(want.status), IDX_W'(got.status));
                    check_field("last", IDX_W'(want.last), IDX_W'(got.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_in_acc <= n_in_acc + 1;
                work_out_positions(s_axis_tuser, s_axis_tdata[OPER_W-1:0]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial begin : run_main
        logic [OPER_W-1:0] n_leaves;
        logic [IDX_W-1:0]  sz;
        logic [1:0]        cmd;

        // node info: leaves both sides, inner nodes, widest positions
        add_cmd(CMD_NODE_INFO, 62'd0);
        add_cmd(CMD_NODE_INFO, 62'd1);
        add_cmd(CMD_NODE_INFO, 62'd2);
        add_cmd(CMD_NODE_INFO, 62'd3);
        add_cmd(CMD_NODE_INFO, 62'd4);
        add_cmd(CMD_NODE_INFO, 62'd6);
        add_cmd(CMD_NODE_INFO, OPND_MAX);
        add_cmd(CMD_NODE_INFO, OPND_MAX - 62'd1);
        // peaks: empty, single peak, incomplete, several peaks, most peaks
        add_cmd(CMD_PEAKS, 62'd0);
        add_cmd(CMD_PEAKS, 62'd1);
        add_cmd(CMD_PEAKS, 62'd2);
        add_cmd(CMD_PEAKS, 62'd4);
        add_cmd(CMD_PEAKS, 62'd5);
        add_cmd(CMD_PEAKS, 62'd10);
        add_cmd(CMD_PEAKS, OPND_MAX);
        add_cmd(CMD_PEAKS, 62'h3FFF_FFFF_FFFF_FFC1);
        // leaf count from the first and last positions
        add_cmd(CMD_LEAF_COUNT, 62'd0);
        add_cmd(CMD_LEAF_COUNT, 62'd1);
        add_cmd(CMD_LEAF_COUNT, 62'd2);
        add_cmd(CMD_LEAF_COUNT, OPND_MAX);
        // leaf position, zero to the widest index
        add_cmd(CMD_LEAF_POS, 62'd0);
        add_cmd(CMD_LEAF_POS, 62'd1);
        add_cmd(CMD_LEAF_POS, 62'd3);
        add_cmd(CMD_LEAF_POS, OPND_MAX);

        // random part: peaks mostly get sizes of real ranges
        for (int i = 0; i < 446; i++) begin
            cmd = 2'($urandom_range(0, 3));
            if (cmd == CMD_PEAKS && $urandom_range(0, 3) != 0) begin
                n_leaves = spread_value() >> 1;
                sz       = 64'd2 * n_leaves - ones_in(n_leaves);
                add_cmd(CMD_PEAKS, sz[OPER_W-1:0]);
            end else begin
                add_cmd(cmd, spread_value());
            end
        end

        @(posedge i_rst_n);
        // every word offered and taken
        while (cmd_words.size() != 0 || n_in_acc != n_in_sent) @(posedge i_clk);
        // every predicted word received
        while (positions_due.size() != 0) @(posedge i_clk);
        // room for stray words beyond the last one expected
        repeat (200) @(posedge i_clk);
        if (positions_due.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, positions_due.size());
            n_errors = n_errors + 1;
        end
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/mmr_pkg.sv
rtl/core/mmr_search.sv
rtl/core/mmr_peak_walk.sv
rtl/core/mmr_position_calculator_top.sv
tb/mmr_position_calculator_top_tb.sv
